FILE: rtl/stencil_block_update_checksum_top_macros.svh
// assertion macros shared by the checker
`ifndef STENCIL_BLOCK_UPDATE_CHECKSUM_TOP_MACROS_SVH
`define STENCIL_BLOCK_UPDATE_CHECKSUM_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define SBUC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("sbuc assertion failed");

// next-cycle implication, held off during reset
`define SBUC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("sbuc assertion failed");

`endif

FILE: rtl/sbuc_pkg.sv
`default_nettype none
package sbuc_pkg;
	localparam int SUB_WIDTH_DEF = 8;
	localparam int SAMPLE_W      = 20;
	localparam int CHK_W         = 32;
	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int S_TDATA_W     = 24;
	localparam int M_TDATA_W     = 56;
	localparam int COEF_W        = 35;

	localparam logic [CFG_IDX_W-1:0] REG_COURANT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOL     = 2'd1;
	localparam logic [CFG_W-1:0]     COURANT_RST = 16'd32768;
	localparam logic [CFG_W-1:0]     TOL_RST     = 16'd64;

	// what a multiplier term belongs to
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_CC   = 2'd0;
	localparam kind_t KIND_FLUX = 2'd1;
	localparam kind_t KIND_STEN = 2'd2;
	localparam kind_t KIND_SUM  = 2'd3;
endpackage
`default_nettype wire

FILE: rtl/stencil_block_update_checksum_top.sv
// channel   dir  tdata (low bit up)                         tlast        tuser
// s_axis    in   sample[19:0], zero pad to 24               -            -
// m_axis    out  new_value[19:0], conserved_sum[51:20], pad  final_value  check_passed
// cfg       in   cfg_we / cfg_index / cfg_data, index 0 courant_number, 1 check_tolerance
//
// a block is 3*SUB_WIDTH+3 input beats, one per cycle while s_tready is high
// compute is done by the single 35x20 multiplier, issuing one product per cycle while
// a sweep is issued (3 per stencil point) and waiting in ST_DRAIN between sweeps
// then SUB_WIDTH+1 result beats, each read, loaded and offered, plus any m_tready stall
// s_tready is low from the last sample of a block until its last result is taken
// reset (arst_n low) clears the sequencer, counters and most registers to their defaults
`default_nettype none
module stencil_block_update_checksum_top #(
	parameter int SUB_WIDTH = sbuc_pkg::SUB_WIDTH_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_tvalid,
	output logic                            s_tready,
	input  wire  [sbuc_pkg::S_TDATA_W-1:0]  s_tdata,   // sample
	output logic                            m_tvalid,
	input  wire                             m_tready,
	output logic [sbuc_pkg::M_TDATA_W-1:0]  m_tdata,   // new_value, conserved_sum
	output logic                            m_tlast,   // final_value
	output logic                            m_tuser,   // check_passed
	input  wire                             cfg_we,
	input  wire  [sbuc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [sbuc_pkg::CFG_W-1:0]      cfg_data
);
	localparam int WS_LEN    = 3 * SUB_WIDTH + 1;
	localparam int BLOCK_LEN = 3 * SUB_WIDTH + 3;
	localparam int AW        = $clog2(WS_LEN);
	localparam int NW        = $clog2(BLOCK_LEN);
	localparam int EW        = $clog2(SUB_WIDTH + 1);
	localparam int RW        = sbuc_pkg::SAMPLE_W + NW;
	localparam int SW        = sbuc_pkg::SAMPLE_W + $clog2(SUB_WIDTH + 2);
	localparam int CW        = sbuc_pkg::COEF_W;
	localparam int PW        = CW + sbuc_pkg::SAMPLE_W;
	localparam int ACW       = PW + 2;

	localparam logic [3:0] ST_LOAD     = 4'd0;
	localparam logic [3:0] ST_CC       = 4'd1;
	localparam logic [3:0] ST_CCW      = 4'd2;
	localparam logic [3:0] ST_COEF     = 4'd3;
	localparam logic [3:0] ST_FLUX     = 4'd4;
	localparam logic [3:0] ST_STEN     = 4'd5;
	localparam logic [3:0] ST_DRAIN    = 4'd6;
	localparam logic [3:0] ST_SUM      = 4'd7;
	localparam logic [3:0] ST_SUM_END  = 4'd8;
	localparam logic [3:0] ST_CHECK    = 4'd9;
	localparam logic [3:0] ST_EMIT_RD  = 4'd10;
	localparam logic [3:0] ST_EMIT_LD  = 4'd11;
	localparam logic [3:0] ST_EMIT_OUT = 4'd12;

	logic [3:0] state_q;
	logic [sbuc_pkg::CFG_W-1:0] cn_q, tol_q;
	logic [NW-1:0] load_q;
	logic signed [RW-1:0] run_q;
	logic [31:0] cc_q;
	logic signed [CW-1:0] ca_q, cb_q, cd_q, clf_q, crf_q;
	logic signed [sbuc_pkg::CHK_W-1:0] chk_q;
	logic [EW-1:0] t_q, e_q;
	logic [AW-1:0] ri_q, k_q;
	logic [1:0] j_q;
	logic signed [SW-1:0] sum_q;
	logic pass_q;
	logic signed [sbuc_pkg::SAMPLE_W-1:0] out_val_q;
	logic out_last_q, out_v_q;

	logic signed [sbuc_pkg::SAMPLE_W-1:0] ws_mem [WS_LEN];

	// term pipeline
	logic v_s1, first_s1, last_s1;
	sbuc_pkg::kind_t kind_s1;
	logic [AW-1:0] dest_s1;
	logic signed [CW-1:0] coef_s1;
	logic signed [sbuc_pkg::SAMPLE_W-1:0] rd_data_s1;
	logic v_s2, first_s2, last_s2;
	sbuc_pkg::kind_t kind_s2;
	logic [AW-1:0] dest_s2;
	logic signed [PW-1:0] prod_s2;
	logic done_s3;
	sbuc_pkg::kind_t kind_s3;
	logic [AW-1:0] dest_s3;
	logic signed [ACW-1:0] acc_q;

	logic iss_v, iss_first, iss_last, rd_en;
	sbuc_pkg::kind_t iss_kind;
	logic [AW-1:0] iss_addr;
	logic signed [CW-1:0] iss_coef;

	logic s_acc, m_acc;
	logic signed [sbuc_pkg::SAMPLE_W-1:0] s_sample;
	logic [NW-1:0] ld_idx;
	logic ld_wr;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic signed [sbuc_pkg::SAMPLE_W-1:0] wr_data;

	logic signed [ACW-1:0] acc_rnd;
	logic signed [23:0] rnd;
	logic signed [sbuc_pkg::SAMPLE_W-1:0] rnd_sat;
	logic signed [33:0] chk_dif;
	logic signed [sbuc_pkg::CHK_W-1:0] chk_sat;
	logic signed [33:0] sum_dif, tol_x;
	logic pipe_empty;

	logic signed [CW-1:0] c32, ccx, one_q33;

	assign s_tready = (state_q == ST_LOAD);
	assign s_acc    = s_tvalid && s_tready;
	assign m_acc    = m_tvalid && m_tready;
	assign s_sample = s_tdata[sbuc_pkg::SAMPLE_W-1:0];
	assign m_tvalid = out_v_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = pass_q;
	assign m_tdata  = {{(sbuc_pkg::M_TDATA_W - sbuc_pkg::CHK_W - sbuc_pkg::SAMPLE_W){1'b0}},
		chk_q, out_val_q};

	assign pipe_empty = !v_s1 && !v_s2 && !done_s3;

	assign c32     = $signed({3'b0, cn_q, 16'b0});
	assign ccx     = $signed({3'b0, cc_q});
	assign one_q33 = $signed({2'b01, 33'b0});

	// rounding half up to q3.16, then the two saturations
	assign acc_rnd = acc_q + $signed({{(ACW-33){1'b0}}, 1'b1, 32'b0});
	assign rnd     = acc_rnd[ACW-1:33];
	always_comb begin
		if (rnd > 24'sd524287)
			rnd_sat = 20'sd524287;
		else if (rnd < -24'sd524288)
			rnd_sat = -20'sd524288;
		else
			rnd_sat = rnd[sbuc_pkg::SAMPLE_W-1:0];
	end
	assign chk_dif = {{2{chk_q[31]}}, chk_q} - {{10{rnd[23]}}, rnd};
	always_comb begin
		if (chk_dif > 34'sd2147483647)
			chk_sat = 32'sh7fffffff;
		else if (chk_dif < -34'sd2147483648)
			chk_sat = 32'sh80000000;
		else
			chk_sat = chk_dif[31:0];
	end
	assign sum_dif = {{(34-SW){sum_q[SW-1]}}, sum_q} - {{2{chk_q[31]}}, chk_q};
	assign tol_x   = $signed({18'b0, tol_q});

	// load address: the ghost samples of the left and center segments are dropped
	always_comb begin
		ld_wr  = 1'b1;
		ld_idx = load_q;
		if (load_q < NW'(SUB_WIDTH)) begin
			ld_idx = load_q;
		end else if (load_q == NW'(SUB_WIDTH) || load_q == NW'(2 * SUB_WIDTH + 1)) begin
			ld_wr = 1'b0;
		end else if (load_q <= NW'(2 * SUB_WIDTH)) begin
			ld_idx = load_q - NW'(1);
		end else begin
			ld_idx = load_q - NW'(2);
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ld_idx[AW-1:0];
		wr_data = s_sample;
		if (s_acc && ld_wr) begin
			wr_en = 1'b1;
		end else if (done_s3 && kind_s3 == sbuc_pkg::KIND_STEN) begin
			wr_en   = 1'b1;
			wr_addr = dest_s3;
			wr_data = rnd_sat;
		end
	end

	// term issue
	always_comb begin
		iss_v     = 1'b0;
		iss_first = 1'b0;
		iss_last  = 1'b0;
		iss_kind  = sbuc_pkg::KIND_STEN;
		iss_addr  = '0;
		iss_coef  = '0;
		rd_en     = 1'b0;
		case (state_q)
			ST_CC: begin
				iss_v     = 1'b1;
				iss_kind  = sbuc_pkg::KIND_CC;
				iss_coef  = $signed({19'b0, cn_q});
				iss_first = 1'b1;
				iss_last  = 1'b1;
			end
			ST_FLUX: begin
				iss_v    = 1'b1;
				iss_kind = sbuc_pkg::KIND_FLUX;
				case (j_q)
					2'd0: begin
						iss_addr  = '0;
						iss_coef  = clf_q;
						iss_first = 1'b1;
					end
					2'd1: begin
						iss_addr = AW'(1);
						iss_coef = cd_q;
						iss_last = 1'b1;
					end
					2'd2: begin
						iss_addr  = ri_q;
						iss_coef  = ca_q;
						iss_first = 1'b1;
					end
					default: begin
						iss_addr = ri_q + AW'(1);
						iss_coef = crf_q;
						iss_last = 1'b1;
					end
				endcase
			end
			ST_STEN: begin
				iss_v     = 1'b1;
				iss_addr  = k_q + AW'(j_q);
				iss_first = (j_q == 2'd0);
				iss_last  = (j_q == 2'd2);
				case (j_q)
					2'd0:    iss_coef = ca_q;
					2'd1:    iss_coef = cb_q;
					default: iss_coef = cd_q;
				endcase
			end
			ST_SUM: begin
				iss_v    = 1'b1;
				iss_kind = sbuc_pkg::KIND_SUM;
				iss_addr = AW'(e_q);
			end
			ST_EMIT_RD: begin
				iss_addr = AW'(e_q);
			end
			default: begin
				iss_v = 1'b0;
			end
		endcase
		rd_en = iss_v || (state_q == ST_EMIT_RD);
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			ws_mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (iss_kind == sbuc_pkg::KIND_CC && iss_v)
				rd_data_s1 <= $signed({4'b0, cn_q});
			else
				rd_data_s1 <= ws_mem[iss_addr];
		end
	end

	// payload of the term pipeline
	always_ff @(posedge clk) begin
		coef_s1  <= iss_coef;
		kind_s1  <= iss_kind;
		first_s1 <= iss_first;
		last_s1  <= iss_last;
		dest_s1  <= k_q;
		prod_s2  <= coef_s1 * rd_data_s1;
		kind_s2  <= kind_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		dest_s2  <= dest_s1;
		kind_s3  <= kind_s2;
		dest_s3  <= dest_s2;
		if (v_s2) begin
			if (first_s2)
				acc_q <= {{2{prod_s2[PW-1]}}, prod_s2};
			else
				acc_q <= acc_q + {{2{prod_s2[PW-1]}}, prod_s2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done_s3 <= 1'b0;
		end else begin
			v_s1    <= iss_v;
			v_s2    <= v_s1 && (kind_s1 != sbuc_pkg::KIND_SUM);
			done_s3 <= v_s2 && last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cn_q       <= sbuc_pkg::COURANT_RST;
			tol_q      <= sbuc_pkg::TOL_RST;
			state_q    <= ST_LOAD;
			load_q     <= '0;
			run_q      <= '0;
			cc_q       <= '0;
			ca_q       <= '0;
			cb_q       <= '0;
			cd_q       <= '0;
			clf_q      <= '0;
			crf_q      <= '0;
			chk_q      <= '0;
			t_q        <= '0;
			e_q        <= '0;
			ri_q       <= '0;
			k_q        <= '0;
			j_q        <= '0;
			sum_q      <= '0;
			pass_q     <= 1'b0;
			out_val_q  <= '0;
			out_last_q <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sbuc_pkg::REG_COURANT: cn_q  <= cfg_data;
					sbuc_pkg::REG_TOL:     tol_q <= cfg_data;
					default:               ;
				endcase
			end

			if (done_s3) begin
				case (kind_s3)
					sbuc_pkg::KIND_CC:   cc_q  <= acc_q[31:0];
					sbuc_pkg::KIND_FLUX: chk_q <= chk_sat;
					default:             ;
				endcase
			end

			if (v_s1 && kind_s1 == sbuc_pkg::KIND_SUM)
				sum_q <= sum_q + {{(SW - sbuc_pkg::SAMPLE_W){rd_data_s1[19]}}, rd_data_s1};

			case (state_q)
				ST_LOAD: begin
					if (s_acc) begin
						if (load_q != NW'(SUB_WIDTH + 1) && load_q != NW'(2 * SUB_WIDTH + 2))
							run_q <= run_q + {{(RW - sbuc_pkg::SAMPLE_W){s_sample[19]}}, s_sample};
						if (load_q == NW'(BLOCK_LEN - 1)) begin
							load_q  <= '0;
							state_q <= ST_CC;
						end else begin
							load_q <= load_q + NW'(1);
						end
					end
				end
				ST_CC: begin
					state_q <= ST_CCW;
				end
				ST_CCW: begin
					if (done_s3 && kind_s3 == sbuc_pkg::KIND_CC)
						state_q <= ST_COEF;
				end
				ST_COEF: begin
					ca_q    <= c32 + ccx;
					cb_q    <= one_q33 - (ccx <<< 1);
					cd_q    <= ccx - c32;
					clf_q   <= one_q33 - c32 - ccx;
					crf_q   <= one_q33 + c32 - ccx;
					chk_q   <= {{(sbuc_pkg::CHK_W - RW){run_q[RW-1]}}, run_q};
					run_q   <= '0;
					t_q     <= '0;
					ri_q    <= AW'(3 * SUB_WIDTH - 1);
					j_q     <= '0;
					state_q <= ST_FLUX;
				end
				ST_FLUX: begin
					if (j_q == 2'd3) begin
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_STEN;
					end else begin
						j_q <= j_q + 2'd1;
					end
				end
				ST_STEN: begin
					if (j_q == 2'd2) begin
						j_q <= '0;
						k_q <= k_q + AW'(1);
						if (k_q == ri_q - AW'(1))
							state_q <= ST_DRAIN;
					end else begin
						j_q <= j_q + 2'd1;
					end
				end
				ST_DRAIN: begin
					// sweep results must be in the workspace before the next flux reads
					if (pipe_empty) begin
						if (t_q == EW'(SUB_WIDTH - 1)) begin
							e_q     <= '0;
							sum_q   <= '0;
							state_q <= ST_SUM;
						end else begin
							t_q     <= t_q + EW'(1);
							ri_q    <= ri_q - AW'(2);
							j_q     <= '0;
							state_q <= ST_FLUX;
						end
					end
				end
				ST_SUM: begin
					if (e_q == EW'(SUB_WIDTH)) begin
						e_q     <= '0;
						state_q <= ST_SUM_END;
					end else begin
						e_q <= e_q + EW'(1);
					end
				end
				ST_SUM_END: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					pass_q  <= (sum_dif <= tol_x) && (sum_dif >= -tol_x);
					state_q <= ST_EMIT_RD;
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					out_val_q  <= rd_data_s1;
					out_last_q <= (e_q == EW'(SUB_WIDTH));
					out_v_q    <= 1'b1;
					state_q    <= ST_EMIT_OUT;
				end
				ST_EMIT_OUT: begin
					if (m_acc) begin
						out_v_q <= 1'b0;
						if (out_last_q) begin
							e_q     <= '0;
							state_q <= ST_LOAD;
						end else begin
							e_q     <= e_q + EW'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/sbuc_checker.sv
`default_nettype none
`include "stencil_block_update_checksum_top_macros.svh"
module sbuc_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            s_tready,
	input wire                            m_tvalid,
	input wire                            m_tready,
	input wire [sbuc_pkg::M_TDATA_W-1:0]  m_tdata,
	input wire                            m_tlast,
	input wire                            m_tuser
);
	// a result beat on offer holds until taken
	`SBUC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`SBUC_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready,
		$stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
	// no sample is taken while results of a block are being delivered
	`SBUC_ASSERT_NOW(a_no_load_in_emit, clk, arst_n, m_tvalid, !s_tready)
	// taking the last result of a block frees the input side and clears m_tvalid
	`SBUC_ASSERT_NEXT(a_ready_after_last, clk, arst_n, m_tvalid && m_tready && m_tlast,
		s_tready && !m_tvalid)
endmodule

bind stencil_block_update_checksum_top sbuc_checker u_sbuc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
`default_nettype wire
